// ===== rtl/assert_macros.svh =====
// assertion macros shared by the packer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define LWGP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define LWGP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define LWGP_ASSERT(lbl, prop, msg)
`define LWGP_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/lwgp_pkg.sv =====
// types and constants of the lane word to group packer
package lwgp_pkg;

	localparam int LANES      = 4;
	localparam int GROUP_SIZE = 8;
	localparam int ELEM_W     = 64;
	localparam int COUNT_W    = 8;
	localparam int TOTAL_W    = 64;

	localparam int CNT_W  = $clog2(LANES + 1);
	localparam int FILL_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int POS_W  = $clog2(GROUP_SIZE + LANES);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

	typedef logic [ELEM_W-1:0] elem_t;
	typedef elem_t [GROUP_SIZE-1:0] grp_arr_t;
	typedef elem_t [LANES-1:0] lane_arr_t;

	typedef struct packed {
		elem_t               lane_0;
		elem_t               lane_1;
		elem_t               lane_2;
		elem_t               lane_3;
		logic [COUNT_W-1:0]  valid_count;
	} word_t;

	typedef struct packed {
		elem_t               group_elem_0;
		elem_t               group_elem_1;
		elem_t               group_elem_2;
		elem_t               group_elem_3;
		elem_t               group_elem_4;
		elem_t               group_elem_5;
		elem_t               group_elem_6;
		elem_t               group_elem_7;
		logic                is_group;
		logic [TOTAL_W-1:0]  total_elements;
		logic                run_last;
	} group_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [FILL_W-1:0] fill;
	} lane_ctl_t;

	typedef struct packed {
		logic              en;
		logic              wrap;
		logic [FILL_W-1:0] slot;
	} slot_t;

	typedef struct packed {
		logic   v0;
		logic   v1;
		group_t d0;
		group_t d1;
	} push_t;

endpackage

// ===== rtl/lwgp_lane.sv =====
// one lane: finds the group slot its element lands in
module lwgp_lane import lwgp_pkg::*; (
	input  logic [CNT_W-1:0] lane_idx,
	input  lane_ctl_t        ctl,
	output slot_t            slot
);

	logic [POS_W-1:0] pos;

	always_comb begin
		pos       = POS_W'(ctl.fill) + POS_W'(lane_idx);
		slot.en   = lane_idx < ctl.cnt;
		slot.wrap = pos >= POS_W'(GROUP_SIZE);
		if (slot.wrap) begin
			slot.slot = FILL_W'(pos - POS_W'(GROUP_SIZE));
		end else begin
			slot.slot = FILL_W'(pos);
		end
	end

endmodule

// ===== rtl/lwgp_merge.sv =====
// merge stage: writes lane elements into the group buffer and forms results
`include "assert_macros.svh"
module lwgp_merge import lwgp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  word_t                   word,
	input  slot_t [LANES-1:0]       slots,
	output lane_ctl_t               ctl,
	output push_t                   push
);

	grp_arr_t            buf_q;
	logic [FILL_W-1:0]   fill_q;
	logic [TOTAL_W-1:0]  total_q;

	lane_arr_t           lanes;
	grp_arr_t            cur;
	grp_arr_t            nxt;
	logic [CNT_W-1:0]    cnt;
	logic                eop;
	logic [POS_W-1:0]    sum;
	logic                full;

	function automatic group_t make_group(grp_arr_t e, logic is_g,
			logic [TOTAL_W-1:0] tot, logic last);
		group_t g;
		g.group_elem_0   = e[0];
		g.group_elem_1   = e[1];
		g.group_elem_2   = e[2];
		g.group_elem_3   = e[3];
		g.group_elem_4   = e[4];
		g.group_elem_5   = e[5];
		g.group_elem_6   = e[6];
		g.group_elem_7   = e[7];
		g.is_group       = is_g;
		g.total_elements = tot;
		g.run_last       = last;
		return g;
	endfunction

	assign lanes = {word.lane_3, word.lane_2, word.lane_1, word.lane_0};
	assign eop   = word.valid_count == '0;
	assign cnt   = (word.valid_count > COUNT_W'(LANES)) ? CNT_W'(LANES)
		: CNT_W'(word.valid_count);
	assign sum   = POS_W'(fill_q) + POS_W'(cnt);
	assign full  = sum >= POS_W'(GROUP_SIZE);

	assign ctl.cnt  = cnt;
	assign ctl.fill = fill_q;

	always_comb begin
		cur = buf_q;
		nxt = '0;
		for (int l = 0; l < LANES; l++) begin
			if (slots[l].en) begin
				if (slots[l].wrap) begin
					nxt[slots[l].slot] = lanes[l];
				end else begin
					cur[slots[l].slot] = lanes[l];
				end
			end
		end
	end

	always_comb begin
		push.v0 = 1'b0;
		push.v1 = 1'b0;
		push.d0 = make_group(cur, 1'b1, '0, 1'b1);
		push.d1 = make_group('0, 1'b0, total_q, 1'b1);
		if (take) begin
			if (eop) begin
				push.v0 = 1'b1;
				if (fill_q != '0) begin
					push.v1 = 1'b1;
					push.d0 = make_group(buf_q, 1'b1, '0, 1'b0);
				end else begin
					push.d0 = make_group('0, 1'b0, total_q, 1'b1);
				end
			end else if (full) begin
				push.v0 = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (take) begin
			if (eop) begin
				buf_q   <= '0;
				fill_q  <= '0;
				total_q <= '0;
			end else begin
				total_q <= total_q + TOTAL_W'(cnt);
				if (full) begin
					buf_q  <= nxt;
					fill_q <= FILL_W'(sum - POS_W'(GROUP_SIZE));
				end else begin
					buf_q  <= cur;
					fill_q <= FILL_W'(sum);
				end
			end
		end
	end

	`LWGP_ASSERT(a_end_clears, take && eop |=> fill_q == '0 && total_q == '0, "frame end left state")
	`LWGP_ASSERT(a_total_adds, take && !eop |=> total_q == $past(total_q) + TOTAL_W'($past(cnt)), "total miscounted")
	`LWGP_NEVER(a_push_idle, !take && (push.v0 || push.v1), "result without a beat")

endmodule

// ===== rtl/lwgp_fifo.sv =====
// result queue: takes up to two results a cycle and hands out one
`include "assert_macros.svh"
module lwgp_fifo import lwgp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output group_t head,
	output logic   head_valid,
	output logic   no_room
);

	group_t [FIFO_DEPTH-1:0] mem_q;
	logic [PTR_W-1:0]        wr_q;
	logic [PTR_W-1:0]        rd_q;
	logic [LVL_W-1:0]        level_q;
	logic [LVL_W-1:0]        npush;

	assign npush      = LVL_W'(push.v0) + LVL_W'(push.v1);
	assign head       = mem_q[rd_q];
	assign head_valid = level_q != '0;
	assign no_room    = level_q > LVL_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.d0;
		end
		if (push.v1) begin
			mem_q[wr_q + PTR_W'(1)] <= push.d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(npush);
			rd_q    <= rd_q + PTR_W'(pop);
			level_q <= level_q + npush - LVL_W'(pop);
		end
	end

	`LWGP_NEVER(a_overflow, (level_q + npush) > LVL_W'(FIFO_DEPTH), "result queue overflow")
	`LWGP_ASSERT(a_first_head, level_q == '0 && push.v0 |=> head == $past(push.d0), "wrong head after push")
	`LWGP_NEVER(a_push_order, push.v1 && !push.v0, "second slot pushed alone")

endmodule

// ===== rtl/lane_word_to_group_packer.sv =====
// top level of the lane word to group packer
// Usage:
// word channel: one beat carries four 64-bit lanes and a valid count; lanes
//   0 up to the count (saturated at four) are appended to an eight element
//   group; a count of zero ends the frame.
// res channel: one beat per result; a full group, a zero padded partial
//   group at frame end, then an end marker with is_group low carrying the
//   frame's element count; run_last marks the last result of a word beat.
// Both channels move a beat when valid is high and stall is low.
// Results are queued and each is offered once the results ahead of it have left.
// Throughput: one word beat per cycle while word_stall is low; lane placement is one
//   adder per lane and the merge writes the buffer in the same cycle. Results leave at
//   one per cycle while res_stall is low, through a four entry queue; word_stall rises
//   while the queue holds more than two results, and an end beat that yields two
//   results pushes both at once, after which they leave one after the other.
// Reset clears the group buffer, fill and element count and empties the queue;
//   word_stall is low as soon as reset is released.
// While res_stall is high the head result holds and words keep flowing until
//   the queue is nearly full.
module lane_word_to_group_packer import lwgp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   word_valid,
	output logic   word_stall,
	input  word_t  word,
	output logic   res_valid,
	input  logic   res_stall,
	output group_t res
);

	lane_ctl_t          ctl;
	slot_t [LANES-1:0]  slots;
	push_t              push;
	logic               take;
	logic               no_room;

	assign take       = word_valid && !word_stall;
	assign word_stall = no_room;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lwgp_lane u_lane (
			.lane_idx (CNT_W'(i)),
			.ctl      (ctl),
			.slot     (slots[i])
		);
	end

	lwgp_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (word),
		.slots  (slots),
		.ctl    (ctl),
		.push   (push)
	);

	lwgp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (res_valid && !res_stall),
		.head       (res),
		.head_valid (res_valid),
		.no_room    (no_room)
	);

endmodule
